FILE: hw/rtl/fxlz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxlz_pkg
// Shared constants and the queue item type of the xor leading-zero packer.
// ----------------------------------------------------------------------------
package fxlz_pkg;

	localparam int WORD_BITS  = 32;
	localparam int ZC_BITS    = 4;
	localparam int ZERO_CAP   = (1 << ZC_BITS) - 1;
	localparam int CODE_BITS  = WORD_BITS + ZC_BITS;
	localparam int LEN_BITS   = 6;
	localparam int FILL_BITS  = 5;
	localparam int CNT_BITS   = 7;
	localparam int WBUF_BITS  = 2 * WORD_BITS + ZC_BITS;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	// one classified item between front and back
	typedef struct packed {
		logic                 byp;
		logic                 last;
		logic [CODE_BITS-1:0] code;
		logic [LEN_BITS-1:0]  len;
	} item_t;

endpackage

FILE: hw/rtl/fxlz_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxlz_front
// Holds the mode register and turns each input item into a code and length.
// ----------------------------------------------------------------------------
module fxlz_front import fxlz_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic [WORD_BITS-1:0] value_word,
	input  logic [WORD_BITS-1:0] reference_word,
	input  logic                 last_item,
	output item_t                item
);

	logic                 compress_enable_q;
	logic [WORD_BITS-1:0] x;
	logic [WORD_BITS-1:0] x_rev;
	logic [WORD_BITS-1:0] body;
	logic [ZC_BITS-1:0]   zeros;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compress_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			compress_enable_q <= cfg_data;
		end
	end

	assign x = value_word ^ reference_word;

	// leading zero count, stops at the cap
	always_comb begin
		zeros = ZC_BITS'(ZERO_CAP);
		for (int i = ZERO_CAP - 1; i >= 0; i--) begin
			if (x[WORD_BITS-1-i]) begin
				zeros = ZC_BITS'(i);
			end
		end
	end

	// first emitted bit sits lowest, so the xor is sent bit-reversed
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			x_rev[i] = x[WORD_BITS-1-i];
		end
	end

	assign body = x_rev >> zeros;

	always_comb begin
		item.byp  = !compress_enable_q;
		item.last = last_item;
		if (compress_enable_q) begin
			item.code = {body, zeros[0], zeros[1], zeros[2], zeros[3]};
			item.len  = LEN_BITS'(CODE_BITS) - LEN_BITS'(zeros);
		end else begin
			item.code = CODE_BITS'(value_word);
			item.len  = LEN_BITS'(WORD_BITS);
		end
	end

endmodule

FILE: hw/rtl/fxlz_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxlz_queue
// Short item queue that decouples the classifying front from the packer.
// ----------------------------------------------------------------------------
module fxlz_queue import fxlz_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  in_ready,
	input  logic  pop,
	output logic  out_valid,
	output item_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	logic             push_ok;
	logic             pop_ok;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_ok   = push && !full;
	assign pop_ok    = pop && !empty;
	assign in_ready  = !full;
	assign out_valid = !empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok && !push_ok |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not lower count");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop_ok |=> count_q == $past(count_q))
		else $error("full queue changed without pop");

endmodule

FILE: hw/rtl/fxlz_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxlz_back
// Packs codes into 32-bit words in an output reg, one word a cycle unless stalled.
// ----------------------------------------------------------------------------
module fxlz_back import fxlz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // packed_word[31:0], valid_bits[37:32], zero
	output logic                  m_tlast    // last_word
);

	logic                 busy_q;
	logic [WBUF_BITS-1:0] w_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 last_q;
	logic                 byp_q;
	logic [WORD_BITS-1:0] bword_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [FILL_BITS-1:0] fill_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic [LEN_BITS-1:0]  out_bits_q;
	logic                 out_last_q;

	logic                 cur_valid;
	logic                 cur_byp;
	logic                 cur_last;
	logic [WBUF_BITS-1:0] cur_w;
	logic [CNT_BITS-1:0]  cur_cnt;
	logic [WORD_BITS-1:0] cur_bword;
	logic [WBUF_BITS-1:0] load_w;
	logic [CNT_BITS-1:0]  load_cnt;
	logic [CNT_BITS-1:0]  rem;
	logic                 slot_free;
	logic                 step;
	logic                 emit;
	logic [WORD_BITS-1:0] e_word;
	logic [LEN_BITS-1:0]  e_bits;
	logic                 e_last;
	logic                 nx_busy;
	logic [WBUF_BITS-1:0] nx_w;
	logic [CNT_BITS-1:0]  nx_cnt;
	logic [WORD_BITS-1:0] nx_acc;
	logic [FILL_BITS-1:0] nx_fill;

	assign slot_free = !out_valid_q || m_tready;
	assign cur_valid = busy_q || q_valid;

	// a fresh item merges with the partial word as it leaves the queue
	always_comb begin
		if (head.byp) begin
			load_w   = WBUF_BITS'(acc_q);
			load_cnt = CNT_BITS'(fill_q);
		end else begin
			load_w   = WBUF_BITS'(acc_q) | (WBUF_BITS'(head.code) << fill_q);
			load_cnt = CNT_BITS'(fill_q) + CNT_BITS'(head.len);
		end
	end

	assign cur_byp   = busy_q ? byp_q   : head.byp;
	assign cur_last  = busy_q ? last_q  : head.last;
	assign cur_w     = busy_q ? w_q     : load_w;
	assign cur_cnt   = busy_q ? cnt_q   : load_cnt;
	assign cur_bword = busy_q ? bword_q : head.code[WORD_BITS-1:0];
	assign rem       = cur_cnt - CNT_BITS'(WORD_BITS);

	always_comb begin
		step    = 1'b0;
		emit    = 1'b0;
		e_word  = cur_w[WORD_BITS-1:0];
		e_bits  = LEN_BITS'(WORD_BITS);
		e_last  = 1'b0;
		nx_busy = busy_q;
		nx_w    = w_q;
		nx_cnt  = cnt_q;
		nx_acc  = acc_q;
		nx_fill = fill_q;
		if (cur_valid) begin
			if (cur_byp) begin
				if (slot_free) begin
					step = 1'b1;
					emit = 1'b1;
					if (cur_cnt != '0) begin
						// pending bits leave first as a partial word
						e_bits  = cur_cnt[LEN_BITS-1:0];
						nx_busy = 1'b1;
						nx_w    = cur_w;
						nx_cnt  = '0;
					end else begin
						e_word  = cur_bword;
						e_last  = cur_last;
						nx_busy = 1'b0;
						nx_acc  = '0;
						nx_fill = '0;
					end
				end
			end else if (cur_cnt >= CNT_BITS'(WORD_BITS)) begin
				if (slot_free) begin
					step   = 1'b1;
					emit   = 1'b1;
					e_last = cur_last && (rem == '0);
					if (rem >= CNT_BITS'(WORD_BITS) || (cur_last && rem != '0)) begin
						nx_busy = 1'b1;
						nx_w    = cur_w >> WORD_BITS;
						nx_cnt  = rem;
					end else begin
						nx_busy = 1'b0;
						nx_acc  = cur_w[2*WORD_BITS-1:WORD_BITS];
						nx_fill = rem[FILL_BITS-1:0];
					end
				end
			end else if (cur_last) begin
				if (slot_free) begin
					step    = 1'b1;
					emit    = 1'b1;
					e_bits  = cur_cnt[LEN_BITS-1:0];
					e_last  = 1'b1;
					nx_busy = 1'b0;
					nx_acc  = '0;
					nx_fill = '0;
				end
			end else begin
				// short code, stays in the partial word
				step    = 1'b1;
				nx_busy = 1'b0;
				nx_acc  = cur_w[WORD_BITS-1:0];
				nx_fill = cur_cnt[FILL_BITS-1:0];
			end
		end
	end

	assign pop = step && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			acc_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				busy_q <= nx_busy;
				acc_q  <= nx_acc;
				fill_q <= nx_fill;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			w_q     <= nx_w;
			cnt_q   <= nx_cnt;
			last_q  <= cur_last;
			byp_q   <= cur_byp;
			bword_q <= cur_bword;
		end
		if (emit) begin
			out_word_q <= e_word;
			out_bits_q <= e_bits;
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_bits_q, out_word_q};
	assign m_tlast  = out_last_q;

	a_partial_reason: assert property (@(posedge clk) disable iff (!arst_n)
		emit && e_bits != LEN_BITS'(WORD_BITS) |-> e_last || cur_byp)
		else $error("partial word without flush or bypass");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !byp_q |-> cnt_q >= CNT_BITS'(WORD_BITS) || (last_q && cnt_q != '0))
		else $error("packer busy with nothing to send");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit && e_last |=> fill_q == '0 && !busy_q)
		else $error("partial word left after last word");

endmodule

FILE: hw/rtl/float_xor_leading_zero_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_xor_leading_zero_packer
// XORs each float with its reference word and packs leading-zero codes.
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item per handshake, value and reference word, tlast
//   marks the final float of a message. m_* channel: packed 32-bit words
//   with their meaningful bit count, tlast marks the final word.
//   cfg_*: writes compress_enable (1 packs codes, 0 passes words through);
//   write it only while the block is idle.
// path: an accepted item is written into the item queue, then its first word
//   is registered in the output register that drives m_tvalid.
// throughput: s_tready is high while the item queue has room, so items are
//   taken every cycle in bursts; the packer then sends one output word per
//   cycle while m_tready does not stall (up to three words per compressed
//   item, one or two per bypass item), and a compressed item that only tops
//   up the partial word emits no word. The sustained rate is bounded by the
//   single word-wide output register.
// reset: compress mode on, partial word empty, queue and output empty.
// stall: a held m_tready keeps the output word; the packer and then the
//   queue fill, and s_tready drops until words drain.
// ----------------------------------------------------------------------------
module float_xor_leading_zero_packer import fxlz_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,    // compress_enable
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // value_word[31:0], reference_word[63:32]
	input  logic                  s_tlast,     // last_item
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,     // packed_word[31:0], valid_bits[37:32], zero
	output logic                  m_tlast      // last_word
);

	item_t front_item;
	item_t head_item;
	logic  q_valid;
	logic  q_pop;
	logic  push;

	assign push = s_tvalid && s_tready;

	fxlz_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.value_word     (s_tdata[WORD_BITS-1:0]),
		.reference_word (s_tdata[2*WORD_BITS-1:WORD_BITS]),
		.last_item      (s_tlast),
		.item           (front_item)
	);

	fxlz_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.in_ready  (s_tready),
		.pop       (q_pop),
		.out_valid (q_valid),
		.head      (head_item)
	);

	fxlz_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head_item),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
